### hdl/mcp_pkg.sv
// Shared types and constants for the max collinear points block.
// Used by mcp_ctrl, mcp_datapath and max_collinear_points_core.
package mcp_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_BITS  = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANCHOR,
      ST_AWAIT,
      ST_DIR,
      ST_DWAIT,
      ST_DCHECK,
      ST_SCAN,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_COMMIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ANCHOR,
      KIND_DIR,
      KIND_SCAN
   } kind_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      kind_type              kind;
      logic [ADDR_BITS-1:0]  addr;
      logic                  clr_cnt;
      logic                  clr_dup;
      logic                  clr_best;
      logic                  commit_dir;
      logic                  commit_anchor;
      logic                  load_rsp;
   } cmd_type;

   typedef struct packed {
      logic dir_dup;
   } status_type;

endpackage

### hdl/mcp_datapath.sv
// Datapath: point memory, anchor and direction registers, cross product
// pipeline, counters and the best-count result register. Uses mcp_pkg.
module mcp_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  mcp_pkg::cmd_type            cmd,
   input  logic [mcp_pkg::COORD_BITS-1:0] wr_x,
   input  logic [mcp_pkg::COORD_BITS-1:0] wr_y,
   output mcp_pkg::status_type         status,
   output logic [mcp_pkg::CNT_BITS-1:0] rsp_best
);

   logic [mcp_pkg::COORD_BITS-1:0] x_mem [mcp_pkg::MAX_POINTS];
   logic [mcp_pkg::COORD_BITS-1:0] y_mem [mcp_pkg::MAX_POINTS];

   logic signed [mcp_pkg::COORD_BITS-1:0] rd_x_ff, rd_y_ff;
   logic signed [mcp_pkg::COORD_BITS-1:0] anc_x_ff, anc_y_ff;
   logic signed [mcp_pkg::DIFF_BITS-1:0]  dir_dx_ff, dir_dy_ff;
   logic signed [mcp_pkg::DIFF_BITS-1:0]  dxk, dyk;
   logic signed [mcp_pkg::PROD_BITS-1:0]  p1_ff, p2_ff;
   mcp_pkg::kind_type                     kind1_ff;
   logic                                  scan_v_ff;
   logic                                  dir_dup_ff;
   logic [mcp_pkg::CNT_BITS-1:0]          cnt_ff, dup_ff, best_ff, rsp_best_ff;
   logic [mcp_pkg::CNT_BITS-1:0]          dir_score, anc_score;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         x_mem[cmd.addr] <= wr_x;
         y_mem[cmd.addr] <= wr_y;
      end
      if (cmd.rd_en) begin
         rd_x_ff <= x_mem[cmd.addr];
         rd_y_ff <= y_mem[cmd.addr];
      end
   end

   assign dxk = {rd_x_ff[mcp_pkg::COORD_BITS-1], rd_x_ff}
              - {anc_x_ff[mcp_pkg::COORD_BITS-1], anc_x_ff};
   assign dyk = {rd_y_ff[mcp_pkg::COORD_BITS-1], rd_y_ff}
              - {anc_y_ff[mcp_pkg::COORD_BITS-1], anc_y_ff};

   assign dir_score = cnt_ff + mcp_pkg::CNT_BITS'(1);
   assign anc_score = dup_ff + mcp_pkg::CNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind1_ff  <= mcp_pkg::KIND_NONE;
         scan_v_ff <= 1'b0;
      end else begin
         kind1_ff  <= cmd.rd_en ? cmd.kind : mcp_pkg::KIND_NONE;
         scan_v_ff <= (kind1_ff == mcp_pkg::KIND_SCAN);
      end
   end

   // Stage one: latch anchor or direction, and always form both cross products.
   always_ff @(posedge clock) begin
      if (kind1_ff == mcp_pkg::KIND_ANCHOR) begin
         anc_x_ff <= rd_x_ff;
         anc_y_ff <= rd_y_ff;
      end
      if (kind1_ff == mcp_pkg::KIND_DIR) begin
         dir_dx_ff  <= dxk;
         dir_dy_ff  <= dyk;
         dir_dup_ff <= (dxk == '0) && (dyk == '0);
      end
      p1_ff <= dir_dx_ff * dyk;
      p2_ff <= dir_dy_ff * dxk;
   end

   // A point equal to the anchor gives zero cross product, so it joins every line.
   always_ff @(posedge clock) begin
      if (cmd.clr_cnt) begin
         cnt_ff <= '0;
      end else if (scan_v_ff && (p1_ff == p2_ff)) begin
         cnt_ff <= cnt_ff + mcp_pkg::CNT_BITS'(1);
      end
      if (cmd.clr_dup) begin
         dup_ff <= '0;
      end else if (kind1_ff == mcp_pkg::KIND_DIR && dxk == '0 && dyk == '0) begin
         dup_ff <= dup_ff + mcp_pkg::CNT_BITS'(1);
      end
      if (cmd.clr_best) begin
         best_ff <= mcp_pkg::CNT_BITS'(1);
      end else if (cmd.commit_dir && dir_score > best_ff) begin
         best_ff <= dir_score;
      end else if (cmd.commit_anchor && anc_score > best_ff) begin
         best_ff <= anc_score;
      end
      if (cmd.load_rsp) begin
         rsp_best_ff <= best_ff;
      end
   end

   assign status.dir_dup = dir_dup_ff;
   assign rsp_best       = rsp_best_ff;

endmodule

### hdl/mcp_ctrl.sv
// Controller: input handshake, point count, the anchor, direction and scan
// index loops, and the result valid flag. Uses mcp_pkg.
module mcp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mcp_pkg::CNT_BITS-1:0]  rsp_used,
   output logic                          rsp_ovf,
   input  mcp_pkg::status_type           status,
   output mcp_pkg::cmd_type              cmd
);

   mcp_pkg::state_type state_ff, state_in;
   logic [mcp_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [mcp_pkg::CNT_BITS-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [mcp_pkg::CNT_BITS-1:0] used_ff, used_in;
   logic drop_ff, drop_in, ovf_ff, ovf_in, rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcp_pkg::ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      used_ff <= used_in;
      ovf_ff  <= ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      used_in      = used_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.kind     = mcp_pkg::KIND_NONE;
      unique case (state_ff)
         mcp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.addr   = count_ff[mcp_pkg::ADDR_BITS-1:0];
            if (req_tvalid) begin
               if (count_ff < mcp_pkg::CNT_BITS'(mcp_pkg::MAX_POINTS)) begin
                  cmd.wr_en = 1'b1;
                  count_in  = count_ff + mcp_pkg::CNT_BITS'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  cmd.clr_best = 1'b1;
                  i_in         = '0;
                  state_in     = mcp_pkg::ST_ANCHOR;
               end
            end
         end
         mcp_pkg::ST_ANCHOR: begin
            if (i_ff == count_ff) begin
               state_in = mcp_pkg::ST_OUT;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.kind    = mcp_pkg::KIND_ANCHOR;
               cmd.addr    = i_ff[mcp_pkg::ADDR_BITS-1:0];
               cmd.clr_dup = 1'b1;
               j_in        = i_ff + mcp_pkg::CNT_BITS'(1);
               state_in    = mcp_pkg::ST_AWAIT;
            end
         end
         mcp_pkg::ST_AWAIT: begin
            state_in = mcp_pkg::ST_DIR;
         end
         mcp_pkg::ST_DIR: begin
            if (j_ff == count_ff) begin
               cmd.commit_anchor = 1'b1;
               i_in              = i_ff + mcp_pkg::CNT_BITS'(1);
               state_in          = mcp_pkg::ST_ANCHOR;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.kind  = mcp_pkg::KIND_DIR;
               cmd.addr  = j_ff[mcp_pkg::ADDR_BITS-1:0];
               state_in  = mcp_pkg::ST_DWAIT;
            end
         end
         mcp_pkg::ST_DWAIT: begin
            state_in = mcp_pkg::ST_DCHECK;
         end
         mcp_pkg::ST_DCHECK: begin
            if (status.dir_dup) begin
               j_in     = j_ff + mcp_pkg::CNT_BITS'(1);
               state_in = mcp_pkg::ST_DIR;
            end else begin
               cmd.clr_cnt = 1'b1;
               k_in        = i_ff + mcp_pkg::CNT_BITS'(1);
               state_in    = mcp_pkg::ST_SCAN;
            end
         end
         mcp_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.kind  = mcp_pkg::KIND_SCAN;
            cmd.addr  = k_ff[mcp_pkg::ADDR_BITS-1:0];
            k_in      = k_ff + mcp_pkg::CNT_BITS'(1);
            if (k_in == count_ff) begin
               state_in = mcp_pkg::ST_DRAIN1;
            end
         end
         mcp_pkg::ST_DRAIN1: begin
            state_in = mcp_pkg::ST_DRAIN2;
         end
         mcp_pkg::ST_DRAIN2: begin
            state_in = mcp_pkg::ST_COMMIT;
         end
         mcp_pkg::ST_COMMIT: begin
            cmd.commit_dir = 1'b1;
            j_in           = j_ff + mcp_pkg::CNT_BITS'(1);
            state_in       = mcp_pkg::ST_DIR;
         end
         mcp_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               used_in      = count_ff;
               ovf_in       = drop_ff;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               drop_in      = 1'b0;
               state_in     = mcp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_used   = used_ff;
   assign rsp_ovf    = ovf_ff;

endmodule

### hdl/max_collinear_points_core.sv
// Max collinear points core: top level joining mcp_ctrl and mcp_datapath.
// Depends on mcp_pkg.
//
// Points are loaded one beat per cycle into a 1024-entry store; a beat with
// tlast closes the set and starts the search, and further beats wait until the
// result has been handed to the output register. Points beyond 1024 are dropped
// and reported through the overflow flag. The search takes every stored point
// as anchor and every later point as a direction, then streams all later points
// through a cross product pipeline, one memory read per cycle. A new set may be
// loaded while the previous result waits to be taken.
module max_collinear_points_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] px, [31:16] py
   input  logic        req_tlast,   // final_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [10:0] best_count, [21:11] points_used,
                                    // [22] overflowed, [23] zero
);

   mcp_pkg::cmd_type             cmd;
   mcp_pkg::status_type          status;
   logic [mcp_pkg::CNT_BITS-1:0] rsp_best, rsp_used;
   logic                         rsp_ovf;

   mcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_used   (rsp_used),
      .rsp_ovf    (rsp_ovf),
      .status     (status),
      .cmd        (cmd)
   );

   mcp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_x     (req_tdata[15:0]),
      .wr_y     (req_tdata[31:16]),
      .status   (status),
      .rsp_best (rsp_best)
   );

   assign rsp_tdata = {1'b0, rsp_ovf, rsp_used, rsp_best};

   // A store write only happens on an accepted input beat.
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (req_tvalid && req_tready))
      else $error("store written without an accepted beat");

   // The store is never written and read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.rd_en))
      else $error("store write and read collide");

   // Loading the result register raises the output valid.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("result loaded but not presented");

endmodule
